[rtl/bdcs_pkg.sv]
// Shared types and constants for the debounced clock setter.
// Holds the word formats, button event struct, edit mode enum and limits.
// No dependencies.
package bdcs_pkg;

    localparam int unsigned NUM_BTN = 4;

    localparam int unsigned KEY_UP    = 0;
    localparam int unsigned KEY_DOWN  = 1;
    localparam int unsigned KEY_SET   = 2;
    localparam int unsigned KEY_CLEAR = 3;

    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [5:0] MINUTE_MAX    = 6'd59;
    localparam logic [4:0] RESET_HOURS   = 5'd12;
    localparam logic [5:0] RESET_MINUTES = 6'd0;
    localparam logic [5:0] RESET_SECONDS = 6'd0;

    localparam logic [3:0] DEBOUNCE_RESET = 4'd3;
    localparam logic [7:0] HOLD_RESET     = 8'd50;
    localparam logic [3:0] DEBOUNCE_SAT   = 4'd15;
    localparam logic [7:0] HOLD_SAT       = 8'd255;

    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_HOLD     = 1'b1;

    typedef enum logic [1:0] {
        MODE_DISPLAY = 2'd0,
        MODE_HOURS   = 2'd1,
        MODE_MINUTES = 2'd2
    } t_mode;

    typedef struct packed {
        logic [3:0] raw_buttons;
        logic [4:0] rtc_hours;
        logic [5:0] rtc_minutes;
        logic [5:0] rtc_seconds;
    } t_in_word;

    typedef struct packed {
        logic       write_time;
        logic [4:0] new_hours;
        logic [5:0] new_minutes;
        logic [5:0] new_seconds;
        logic [1:0] mode;
    } t_out_word;

    typedef struct packed {
        logic press;
        logic held;
    } t_btn_evt;

endpackage

[rtl/bdcs_button.sv]
// One pushbutton channel: debounce, press edge detection and hold tracking.
// Depends on bdcs_pkg.
module bdcs_button (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_level,
    input  logic [3:0]         i_debounce_polls,
    input  logic [7:0]         i_hold_polls,
    output bdcs_pkg::t_btn_evt o_evt
);
    import bdcs_pkg::*;

    logic       r_stable;
    logic [3:0] r_cnt;
    logic       r_pressed;
    logic       r_held;
    logic [7:0] r_hold_cnt;

    logic       n_stable;
    logic [3:0] n_cnt;
    logic       n_pressed;
    logic       n_held;
    logic [7:0] n_hold_cnt;
    logic       n_press;

    logic [3:0] cnt_inc;
    logic       accept;

    always_comb begin
        cnt_inc    = (r_cnt == DEBOUNCE_SAT) ? DEBOUNCE_SAT : r_cnt + 4'd1;
        accept     = (i_level != r_stable) && (cnt_inc >= i_debounce_polls);
        n_stable   = r_stable;
        n_cnt      = r_cnt;
        n_pressed  = r_pressed;
        n_held     = r_held;
        n_hold_cnt = r_hold_cnt;
        n_press    = 1'b0;
        if (i_level == r_stable) begin
            n_cnt = 4'd0;
        end else if (accept) begin
            n_cnt    = 4'd0;
            n_stable = i_level;
            if (!i_level) begin
                n_pressed  = 1'b1;
                n_hold_cnt = 8'd0;
                n_press    = 1'b1;
            end else begin
                n_pressed = 1'b0;
                n_held    = 1'b0;
            end
        end else begin
            n_cnt = cnt_inc;
        end
        if (n_pressed) begin
            if (n_hold_cnt != HOLD_SAT) begin
                n_hold_cnt = n_hold_cnt + 8'd1;
            end
            if (n_hold_cnt > i_hold_polls) begin
                n_held = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b0;
            r_cnt      <= 4'd0;
            r_pressed  <= 1'b0;
            r_held     <= 1'b0;
            r_hold_cnt <= 8'd0;
        end else if (i_en) begin
            r_stable   <= n_stable;
            r_cnt      <= n_cnt;
            r_pressed  <= n_pressed;
            r_held     <= n_held;
            r_hold_cnt <= n_hold_cnt;
        end
    end

    assign o_evt.press = n_press;
    assign o_evt.held  = n_held;

endmodule

[rtl/bdcs_time_edit.sv]
// Time and edit mode actions: UP, DOWN, SET, RESET applied in order.
// Holds the edit mode register. Depends on bdcs_pkg.
module bdcs_time_edit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bdcs_pkg::t_btn_evt  i_evt [bdcs_pkg::NUM_BTN],
    input  bdcs_pkg::t_in_word  i_word,
    output bdcs_pkg::t_out_word o_word
);
    import bdcs_pkg::*;

    t_mode r_mode;
    t_mode n_mode;

    logic       up;
    logic       down;
    logic       write;
    logic [4:0] hrs_up;
    logic [4:0] hrs;
    logic [5:0] mins_up;
    logic [5:0] mins;
    logic [5:0] secs;

    always_comb begin
        up      = i_evt[KEY_UP].press | i_evt[KEY_UP].held;
        down    = i_evt[KEY_DOWN].press | i_evt[KEY_DOWN].held;
        write   = 1'b0;
        hrs_up  = i_word.rtc_hours;
        mins_up = i_word.rtc_minutes;
        secs    = i_word.rtc_seconds;
        if (up && r_mode == MODE_HOURS) begin
            hrs_up = (i_word.rtc_hours >= HOUR_MAX) ? 5'd0 : i_word.rtc_hours + 5'd1;
            write  = 1'b1;
        end
        if (up && r_mode == MODE_MINUTES) begin
            mins_up = (i_word.rtc_minutes >= MINUTE_MAX) ? 6'd0 : i_word.rtc_minutes + 6'd1;
            write   = 1'b1;
        end
        hrs  = hrs_up;
        mins = mins_up;
        if (down && r_mode == MODE_HOURS) begin
            hrs   = (hrs_up == 5'd0) ? HOUR_MAX : hrs_up - 5'd1;
            write = 1'b1;
        end
        if (down && r_mode == MODE_MINUTES) begin
            mins  = (mins_up == 6'd0) ? MINUTE_MAX : mins_up - 6'd1;
            write = 1'b1;
        end
        n_mode = r_mode;
        if (i_evt[KEY_SET].press) begin
            case (r_mode)
                MODE_DISPLAY: n_mode = MODE_HOURS;
                MODE_HOURS:   n_mode = MODE_MINUTES;
                default:      n_mode = MODE_DISPLAY;
            endcase
        end
        if (i_evt[KEY_CLEAR].press) begin
            hrs    = RESET_HOURS;
            mins   = RESET_MINUTES;
            secs   = RESET_SECONDS;
            write  = 1'b1;
            n_mode = MODE_DISPLAY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DISPLAY;
        end else if (i_en) begin
            r_mode <= n_mode;
        end
    end

    assign o_word.write_time  = write;
    assign o_word.new_hours   = hrs;
    assign o_word.new_minutes = mins;
    assign o_word.new_seconds = secs;
    assign o_word.mode        = n_mode;

endmodule

[rtl/button_debounced_clock_setter_unit.sv]
// Top level of the debounced clock setter.
// Instantiates bdcs_button (four times) and bdcs_time_edit; uses bdcs_pkg.
//
// Usage:
// Input channel: i_valid / o_stall carry one poll word (raw active-low
// buttons plus the time read from the clock chip). Output channel:
// o_valid / i_stall carry one result word per poll: write flag, the time
// after the button actions, and the edit mode.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index (0 debounce
// polls, 1 hold polls) and i_cfg_data; always ready, write only while idle.
// From accept to o_valid a word passes the input register, then the
// debounce and time logic into the result register. One word per cycle
// is sustained while i_stall is low; the button and mode state update as the
// word enters the result register, so consecutive words chain without a gap.
// When the receiver stalls, the result register holds; one more word waits
// in the input register, after which o_stall rises.
// Reset (synchronous, active low) empties both registers, clears all button
// state and the mode to display, and loads debounce 3 and hold 50.
module button_debounced_clock_setter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bdcs_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output bdcs_pkg::t_out_word o_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import bdcs_pkg::*;

    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;
    logic [3:0] r_debounce;
    logic [7:0] r_hold;

    logic       adv_out;
    logic       step;
    logic       accept_in;
    t_btn_evt   evt [NUM_BTN];
    t_out_word  n_out;

    assign adv_out     = !r_out_valid || !i_stall;
    assign step        = r_in_valid && adv_out;
    assign o_stall     = r_in_valid && !adv_out;
    assign accept_in   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
        bdcs_button u_button (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_en             (step),
            .i_level          (r_in.raw_buttons[b]),
            .i_debounce_polls (r_debounce),
            .i_hold_polls     (r_hold),
            .o_evt            (evt[b])
        );
    end

    bdcs_time_edit u_time_edit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_evt   (evt),
        .i_word  (r_in),
        .o_word  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_debounce  <= DEBOUNCE_RESET;
            r_hold      <= HOLD_RESET;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (adv_out) begin
                r_in_valid <= 1'b0;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE: r_debounce <= i_cfg_data[3:0];
                    CFG_HOLD:     r_hold     <= i_cfg_data;
                    default:      r_hold     <= r_hold;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in <= i_word;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule
